### design/occupancy_grid_ray_update_unit_assert.svh
// Assertion helpers shared by the grid update unit.
// Both forms sample on the rising clock edge and stay quiet while reset is high.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_UNIT_ASSERT_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define OGRU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
`define OGRU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define OGRU_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define OGRU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### design/ogru_pkg.sv
`default_nettype none

package ogru_pkg;

  localparam int VAL_W       = 16;
  localparam int CNT_W       = 10;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  // Request kinds on the input channel
  localparam logic REQ_RAY  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Work kinds passed from front to back
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_RAY    = 2'd0;
  localparam op_t OP_READ   = 2'd1;
  localparam op_t OP_REJECT = 2'd2;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_DONE       = 2'd0;
  localparam status_t ST_START_OUT  = 2'd1;
  localparam status_t ST_TARGET_OUT = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FREE_INC    = 2'd0;
  localparam cfg_idx_t CFG_OCC_INC     = 2'd1;
  localparam cfg_idx_t CFG_LOWER_CLAMP = 2'd2;
  localparam cfg_idx_t CFG_UPPER_CLAMP = 2'd3;

  localparam logic signed [VAL_W-1:0] FREE_INC_RST    = -16'sd102;
  localparam logic signed [VAL_W-1:0] OCC_INC_RST     = 16'sd218;
  localparam logic signed [VAL_W-1:0] LOWER_CLAMP_RST = -16'sd1280;
  localparam logic signed [VAL_W-1:0] UPPER_CLAMP_RST = 16'sd1280;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic signed [VAL_W-1:0] free_inc;
    logic signed [VAL_W-1:0] occ_inc;
    logic signed [VAL_W-1:0] lower_clamp;
    logic signed [VAL_W-1:0] upper_clamp;
  } cfg_t;

endpackage

`default_nettype wire

### design/ogru_if.sv
`default_nettype none

interface ogru_req_if;
  import ogru_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic signed [VAL_W-1:0] start_row;
  logic signed [VAL_W-1:0] start_col;
  logic signed [VAL_W-1:0] target_row;
  logic signed [VAL_W-1:0] target_col;

  modport source (output valid, req_type, start_row, start_col, target_row, target_col,
                  input ready);
  modport sink (input valid, req_type, start_row, start_col, target_row, target_col,
                output ready);
endinterface

interface ogru_rsp_if;
  import ogru_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] cell_value;
  logic [CNT_W-1:0]        cells_updated;

  modport source (output valid, status, cell_value, cells_updated, input ready);
  modport sink (input valid, status, cell_value, cells_updated, output ready);
endinterface

`default_nettype wire

### design/ogru_ram.sv
`default_nettype none

module ogru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/ogru_queue.sv
`default_nettype none

module ogru_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  assign full     = (fill == CNT_W'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr        <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/ogru_front.sv
`default_nettype none

module ogru_front #(
  parameter int GRID_WIDTH = 256,
  parameter int GRID_HEIGHT = 256,
  localparam int ROW_W = $clog2(GRID_HEIGHT),
  localparam int COL_W = $clog2(GRID_WIDTH),
  localparam int ADDR_W = $clog2(GRID_WIDTH * GRID_HEIGHT),
  localparam int ENTRY_W = ogru_pkg::OP_W + ogru_pkg::STATUS_W + ADDR_W
                           + 2 * ROW_W + 2 * COL_W
) (
  ogru_req_if.sink            req,
  input  logic                clear_busy,
  input  logic                q_full,
  output logic                q_push,
  output logic [ENTRY_W-1:0]  q_data
);

  import ogru_pkg::*;

  typedef struct packed {
    op_t              op;
    status_t          status;
    logic [ADDR_W-1:0] addr;
    logic [ROW_W-1:0] r0;
    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r1;
    logic [COL_W-1:0] c1;
  } entry_t;

  logic             start_ok;
  logic             target_ok;
  logic [ROW_W-1:0] base_row;
  logic [COL_W-1:0] base_col;
  entry_t           ent;

  assign req.ready = !clear_busy && !q_full;
  assign q_push    = req.valid && req.ready;
  assign q_data    = ent;

  always_comb begin
    start_ok  = !req.start_row[VAL_W-1] && (req.start_row < VAL_W'(GRID_HEIGHT))
             && !req.start_col[VAL_W-1] && (req.start_col < VAL_W'(GRID_WIDTH));
    target_ok = !req.target_row[VAL_W-1] && (req.target_row < VAL_W'(GRID_HEIGHT))
             && !req.target_col[VAL_W-1] && (req.target_col < VAL_W'(GRID_WIDTH));

    // Reads address the target cell, rays start their walk at the start cell
    if (req.req_type == REQ_READ) begin
      base_row = req.target_row[ROW_W-1:0];
      base_col = req.target_col[COL_W-1:0];
    end else begin
      base_row = req.start_row[ROW_W-1:0];
      base_col = req.start_col[COL_W-1:0];
    end

    ent.addr   = ADDR_W'(ADDR_W'(base_row) * ADDR_W'(GRID_WIDTH)) + ADDR_W'(base_col);
    ent.r0     = req.start_row[ROW_W-1:0];
    ent.c0     = req.start_col[COL_W-1:0];
    ent.r1     = req.target_row[ROW_W-1:0];
    ent.c1     = req.target_col[COL_W-1:0];
    ent.status = ST_DONE;
    ent.op     = OP_RAY;

    if (req.req_type == REQ_READ) begin
      if (target_ok) begin
        ent.op = OP_READ;
      end else begin
        ent.op     = OP_REJECT;
        ent.status = ST_TARGET_OUT;
      end
    end else if (!start_ok) begin
      ent.op     = OP_REJECT;
      ent.status = ST_START_OUT;
    end else if (!target_ok) begin
      ent.op     = OP_REJECT;
      ent.status = ST_TARGET_OUT;
    end
  end

endmodule

`default_nettype wire

### design/ogru_back.sv
`default_nettype none
`include "occupancy_grid_ray_update_unit_assert.svh"

module ogru_back #(
  parameter int GRID_WIDTH = 256,
  parameter int GRID_HEIGHT = 256,
  localparam int ROW_W = $clog2(GRID_HEIGHT),
  localparam int COL_W = $clog2(GRID_WIDTH),
  localparam int ADDR_W = $clog2(GRID_WIDTH * GRID_HEIGHT),
  localparam int ENTRY_W = ogru_pkg::OP_W + ogru_pkg::STATUS_W + ADDR_W
                           + 2 * ROW_W + 2 * COL_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ogru_pkg::cfg_t                cfg,
  input  logic                          q_empty,
  input  logic [ENTRY_W-1:0]            q_data,
  output logic                          q_pop,
  output logic                          clear_busy,
  output logic                          ram_wr_en,
  output logic [ADDR_W-1:0]             ram_wr_addr,
  output logic [ogru_pkg::VAL_W-1:0]    ram_wr_data,
  output logic                          ram_rd_en,
  output logic [ADDR_W-1:0]             ram_rd_addr,
  input  logic [ogru_pkg::VAL_W-1:0]    ram_rd_data,
  ogru_rsp_if.source                    rsp
);

  import ogru_pkg::*;

  localparam int DW    = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int EW    = DW + 3;
  localparam int SUM_W = VAL_W + 2;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(GRID_WIDTH * GRID_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(GRID_WIDTH);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  typedef struct packed {
    op_t               op;
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [ROW_W-1:0]  r0;
    logic [COL_W-1:0]  c0;
    logic [ROW_W-1:0]  r1;
    logic [COL_W-1:0]  c1;
  } entry_t;

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [VAL_W-1:0] x);
    return {{(SUM_W - VAL_W){x[VAL_W-1]}}, x};
  endfunction

  function automatic logic signed [VAL_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    if ((&v[SUM_W-1:VAL_W-1]) || !(|v[SUM_W-1:VAL_W-1])) begin
      return v[VAL_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(VAL_W - 1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W - 1){1'b1}}};
    end
  endfunction

  logic [2:0]              state;
  logic [ADDR_W-1:0]       clr_addr;
  logic [ADDR_W-1:0]       addr_q;
  logic [ROW_W-1:0]        r_cur;
  logic [COL_W-1:0]        c_cur;
  logic [ROW_W-1:0]        r_end;
  logic [COL_W-1:0]        c_end;
  logic signed [EW-1:0]    dr_q;
  logic signed [EW-1:0]    dc_q;
  logic signed [EW-1:0]    err_q;
  logic                    r_neg;
  logic                    c_neg;
  logic [CNT_W-1:0]        cnt;
  status_t                 res_status;
  logic signed [VAL_W-1:0] res_value;
  logic [CNT_W-1:0]        res_count;
  logic                    out_valid;
  status_t                 out_status;
  logic signed [VAL_W-1:0] out_value;
  logic [CNT_W-1:0]        out_count;

  entry_t                  ent;
  logic                    at_last;
  logic                    out_load;
  logic signed [VAL_W-1:0] cell_old;
  logic signed [SUM_W-1:0] free_sum;
  logic signed [SUM_W-1:0] hit_sum;
  logic signed [VAL_W-1:0] free_val;
  logic signed [VAL_W-1:0] hit_val;
  logic signed [EW-1:0]    e2;
  logic                    step_r;
  logic                    step_c;
  logic signed [EW-1:0]    err_next;
  logic [ADDR_W-1:0]       addr_row;
  logic [ADDR_W-1:0]       addr_next;
  logic [CNT_W-1:0]        cnt_inc;
  logic [ROW_W-1:0]        dr_u;
  logic [COL_W-1:0]        dc_u;

  assign ent        = entry_t'(q_data);
  assign q_pop      = (state == S_IDLE) && !q_empty;
  assign clear_busy = (state == S_CLEAR);
  assign at_last    = (r_cur == r_end) && (c_cur == c_end);
  assign cell_old   = $signed(ram_rd_data);
  assign out_load   = (state == S_PUSH) && (!out_valid || rsp.ready);

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.cell_value    = out_value;
  assign rsp.cells_updated = out_count;

  always_comb begin
    free_sum = ext(cell_old) + ext(cfg.free_inc);
    if (free_sum < ext(cfg.lower_clamp)) begin
      free_sum = ext(cfg.lower_clamp);
    end
    free_val = sat(free_sum);

    hit_sum = ext(cell_old) + ext(cfg.occ_inc);
    if (hit_sum > ext(cfg.upper_clamp)) begin
      hit_sum = ext(cfg.upper_clamp);
    end
    hit_val = sat(hit_sum);

    e2       = err_q <<< 1;
    step_r   = (e2 > -dc_q);
    step_c   = (e2 < dr_q);
    err_next = err_q - (step_r ? dc_q : '0) + (step_c ? dr_q : '0);

    addr_row = addr_q;
    if (step_r) begin
      addr_row = r_neg ? addr_q - ROW_STEP : addr_q + ROW_STEP;
    end
    addr_next = addr_row;
    if (step_c) begin
      addr_next = c_neg ? addr_row - 1'b1 : addr_row + 1'b1;
    end

    cnt_inc = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;

    dr_u = (ent.r1 > ent.r0) ? ent.r1 - ent.r0 : ent.r0 - ent.r1;
    dc_u = (ent.c1 > ent.c0) ? ent.c1 - ent.c0 : ent.c0 - ent.c1;
  end

  // One read-modify-write per cycle: the word read last cycle is written back
  // while the next cell on the line is read.
  always_comb begin
    ram_wr_en   = (state == S_CLEAR) || (state == S_WALK);
    ram_wr_addr = (state == S_CLEAR) ? clr_addr : addr_q;
    ram_wr_data = (state == S_CLEAR) ? '0 : (at_last ? hit_val : free_val);
    ram_rd_en   = q_pop || ((state == S_WALK) && !at_last);
    ram_rd_addr = (state == S_WALK) ? addr_next : ent.addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            case (ent.op)
              OP_RAY: begin
                addr_q <= ent.addr;
                r_cur  <= ent.r0;
                c_cur  <= ent.c0;
                r_end  <= ent.r1;
                c_end  <= ent.c1;
                dr_q   <= $signed(EW'(dr_u));
                dc_q   <= $signed(EW'(dc_u));
                err_q  <= $signed(EW'(dr_u)) - $signed(EW'(dc_u));
                r_neg  <= !(ent.r0 < ent.r1);
                c_neg  <= !(ent.c0 < ent.c1);
                cnt    <= '0;
                state  <= S_WALK;
              end
              OP_READ: begin
                state <= S_READ;
              end
              default: begin
                res_status <= ent.status;
                res_value  <= '0;
                res_count  <= '0;
                state      <= S_PUSH;
              end
            endcase
          end
        end
        S_READ: begin
          res_status <= ST_DONE;
          res_value  <= cell_old;
          res_count  <= '0;
          state      <= S_PUSH;
        end
        S_WALK: begin
          if (at_last) begin
            res_status <= ST_DONE;
            res_value  <= hit_val;
            res_count  <= cnt_inc;
            state      <= S_PUSH;
          end else begin
            cnt    <= cnt_inc;
            err_q  <= err_next;
            addr_q <= addr_next;
            if (step_r) begin
              r_cur <= r_neg ? r_cur - 1'b1 : r_cur + 1'b1;
            end
            if (step_c) begin
              c_cur <= c_neg ? c_cur - 1'b1 : c_cur + 1'b1;
            end
          end
        end
        S_PUSH: begin
          if (out_load) begin
            out_status <= res_status;
            out_value  <= res_value;
            out_count  <= res_count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `OGRU_ASSERT_IMPL(a_walk_in_map, clk, rst, state == S_WALK, ({1'b0, r_cur} < (ROW_W + 1)'(GRID_HEIGHT)) && ({1'b0, c_cur} < (COL_W + 1)'(GRID_WIDTH)))
  `OGRU_ASSERT_NEXT(a_hit_then_push, clk, rst, (state == S_WALK) && at_last, state == S_PUSH)
  `OGRU_ASSERT_IMPL(a_no_result_in_clear, clk, rst, state == S_CLEAR, !out_valid && q_empty)

endmodule

`default_nettype wire

### design/occupancy_grid_ray_update_unit.sv
`default_nettype none

// Channel   Dir  Handshake      Word
// req       in   valid/ready    req_type, start_row, start_col, target_row, target_col
// rsp       out  valid/ready    status, cell_value, cells_updated
// cfg       in   cfg_wr_en      cfg_index, cfg_wr_data (no back-pressure)
//
// A ray updates every cell on the line, max(|dr|, |dc|) + 1 cells, loading
// from the queue, walking in S_WALK and handing off its result in S_PUSH; a
// read passes through S_READ to S_PUSH and a rejected request goes straight to
// S_PUSH. The grid RAM does one read-modify-write per cell through its single
// write port. After reset the grid is zeroed one word per cycle, with req.ready
// low. A two-entry queue parts front and back, and the output register lets
// the next ray run while a result waits on rsp.ready.

module occupancy_grid_ray_update_unit #(
  parameter int GRID_WIDTH = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  ogru_req_if.sink                        req,
  ogru_rsp_if.source                      rsp,
  input  logic                            cfg_wr_en,
  input  logic [ogru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ogru_pkg::VAL_W-1:0]      cfg_wr_data
);

  import ogru_pkg::*;

  localparam int ROW_W   = $clog2(GRID_HEIGHT);
  localparam int COL_W   = $clog2(GRID_WIDTH);
  localparam int DEPTH   = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ENTRY_W = OP_W + STATUS_W + ADDR_W + 2 * ROW_W + 2 * COL_W;

  cfg_t               cfg;
  logic               clear_busy;
  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_full;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_pop_data;
  logic               q_empty;
  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [VAL_W-1:0]   ram_wr_data;
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [VAL_W-1:0]   ram_rd_data;

  // Update registers; host must write them only while the unit is idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{free_inc:    FREE_INC_RST,
               occ_inc:     OCC_INC_RST,
               lower_clamp: LOWER_CLAMP_RST,
               upper_clamp: UPPER_CLAMP_RST};
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FREE_INC:    cfg.free_inc    <= cfg_wr_data;
        CFG_OCC_INC:     cfg.occ_inc     <= cfg_wr_data;
        CFG_LOWER_CLAMP: cfg.lower_clamp <= cfg_wr_data;
        CFG_UPPER_CLAMP: cfg.upper_clamp <= cfg_wr_data;
        default:         cfg             <= cfg;
      endcase
    end
  end

  // Front: bounds-check the request and form the first grid address
  ogru_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_front (
    .req        (req),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  // Hold classified work while the back walks the previous ray
  ogru_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Back: clear pass, Bresenham walk with read-modify-write, result register
  ogru_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_data      (q_pop_data),
    .q_pop       (q_pop),
    .clear_busy  (clear_busy),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .rsp         (rsp)
  );

  // Log-odds grid, row-major, one Q8.8 word per cell
  ogru_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

### sim/tb_occupancy_grid_ray_update_unit.sv
`timescale 1ns / 1ps

module tb_occupancy_grid_ray_update_unit;
  import ogru_pkg::*;

  localparam int GRID_W = 256;
  localparam int GRID_H = 256;
  localparam int GRID_CELLS = GRID_W * GRID_H;
  // The grid clear after reset alone idles both channels while it zeroes every cell;
  // IDLE_LIMIT leaves a wide margin over that before calling the run hung.
  localparam int IDLE_LIMIT = 4 * GRID_CELLS;
  // Margin after the last response, sized from the longest ray plus load and hand-off.
  localparam int TAIL_CYCLES = 300;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 108;

  typedef struct packed {
    logic                    req_type;
    logic signed [VAL_W-1:0] start_row;
    logic signed [VAL_W-1:0] start_col;
    logic signed [VAL_W-1:0] target_row;
    logic signed [VAL_W-1:0] target_col;
  } ray_req_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] cell_value;
    logic [CNT_W-1:0]        cells_updated;
  } ray_rsp_t;

  typedef struct {
    ray_req_t rq;
    bit       known;
    ray_rsp_t rs;
  } dir_row_t;

  logic clk;
  logic rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_wr_data;

  ogru_req_if req_ch ();
  ogru_rsp_if rsp_ch ();

  occupancy_grid_ray_update_unit #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow of the grid and of the four registers, updated in acceptance order.
  logic signed [VAL_W-1:0] grid_lo [0:GRID_CELLS-1];
  int free_inc_m;
  int occ_inc_m;
  int lo_clamp_m;
  int hi_clamp_m;

  // Responses still owed by the block, oldest first.
  ray_rsp_t awaited_rsp[$];
  dir_row_t dir_rows[$];

  int n_fail;
  int idle_cycles;
  bit no_idle;
  int win_r;
  int win_c;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic ray_req_t mk_req(int kind, int sr, int sc, int tr, int tc);
    ray_req_t w;
    w.req_type = kind[0];
    w.start_row = VAL_W'(sr);
    w.start_col = VAL_W'(sc);
    w.target_row = VAL_W'(tr);
    w.target_col = VAL_W'(tc);
    return w;
  endfunction

  function automatic ray_rsp_t mk_rsp(status_t st, int v, int cnt);
    ray_rsp_t w;
    w.status = st;
    w.cell_value = VAL_W'(v);
    w.cells_updated = cnt[CNT_W-1:0];
    return w;
  endfunction

  function automatic logic signed [VAL_W-1:0] clip16(int s);
    if (s > 32767) return 16'sh7fff;
    if (s < -32768) return 16'sh8000;
    return s[VAL_W-1:0];
  endfunction

  function automatic bit on_grid(int r, int c);
    return r >= 0 && r < GRID_H && c >= 0 && c < GRID_W;
  endfunction

  // Apply one request to the shadow grid and return the response it owes.
  function automatic ray_rsp_t grid_outcome(ray_req_t rq);
    ray_rsp_t res;
    int r0, c0, r1, c1, dr, dc, sr, sc, err, e2, r, c, cnt, idx, s;
    res = '0;
    res.status = ST_DONE;
    r0 = int'($signed(rq.start_row));
    c0 = int'($signed(rq.start_col));
    r1 = int'($signed(rq.target_row));
    c1 = int'($signed(rq.target_col));
    if (rq.req_type == REQ_READ) begin
      if (!on_grid(r1, c1)) res.status = ST_TARGET_OUT;
      else res.cell_value = grid_lo[r1 * GRID_W + c1];
    end else if (!on_grid(r0, c0)) begin
      res.status = ST_START_OUT;
    end else if (!on_grid(r1, c1)) begin
      res.status = ST_TARGET_OUT;
    end else begin
      dr = (r1 > r0) ? r1 - r0 : r0 - r1;
      dc = (c1 > c0) ? c1 - c0 : c0 - c1;
      sr = (r0 < r1) ? 1 : -1;
      sc = (c0 < c1) ? 1 : -1;
      err = dr - dc;
      r = r0;
      c = c0;
      cnt = 0;
      // Walk the line; every cell but the hit cell takes the free update.
      while (!(r == r1 && c == c1)) begin
        e2 = 2 * err;
        idx = r * GRID_W + c;
        s = int'(grid_lo[idx]) + free_inc_m;
        if (s < lo_clamp_m) s = lo_clamp_m;
        grid_lo[idx] = clip16(s);
        cnt++;
        if (e2 > -dc) begin
          err -= dc;
          r += sr;
        end
        if (e2 < dr) begin
          err += dr;
          c += sc;
        end
      end
      idx = r1 * GRID_W + c1;
      s = int'(grid_lo[idx]) + occ_inc_m;
      if (s > hi_clamp_m) s = hi_clamp_m;
      grid_lo[idx] = clip16(s);
      res.cell_value = grid_lo[idx];
      cnt++;
      if (cnt > 1023) cnt = 1023;
      res.cells_updated = cnt[CNT_W-1:0];
    end
    return res;
  endfunction

  task automatic add_row(ray_req_t rq, bit known, ray_rsp_t rs);
    dir_row_t row;
    row.rq = rq;
    row.known = known;
    row.rs = rs;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Present one request word after a random gap, hold it until accepted, then
  // log what it owes. A typed-in expectation overrides the shadow's answer,
  // but the shadow still has to see the request.
  task automatic send_req(ray_req_t w, bit known, ray_rsp_t typed);
    int gap;
    ray_rsp_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= w.req_type;
    req_ch.start_row <= w.start_row;
    req_ch.start_col <= w.start_col;
    req_ch.target_row <= w.target_row;
    req_ch.target_col <= w.target_col;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pred = grid_outcome(w);
    awaited_rsp.insert(awaited_rsp.size(), known ? typed : pred);
  endtask

  // Drop valid and hold off until every owed response has come back.
  task automatic drain_results(int extra);
    req_ch.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_cfg(int f, int o, int l, int u);
    cfg_idx_t idx [4];
    logic signed [VAL_W-1:0] val [4];
    idx = '{CFG_FREE_INC, CFG_OCC_INC, CFG_LOWER_CLAMP, CFG_UPPER_CLAMP};
    val = '{VAL_W'(f), VAL_W'(o), VAL_W'(l), VAL_W'(u)};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wr_data <= val[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    free_inc_m = int'(val[0]);
    occ_inc_m = int'(val[1]);
    lo_clamp_m = int'(val[2]);
    hi_clamp_m = int'(val[3]);
  endtask

  function automatic logic signed [VAL_W-1:0] any16();
    return VAL_W'($urandom_range(0, 65535));
  endfunction

  function automatic int border_coord();
    case ($urandom_range(0, 3))
      0: return -1;
      1: return 0;
      2: return GRID_W - 1;
      default: return GRID_W;
    endcase
  endfunction

  // Most traffic hits a small hot window so cells get hit over and over and
  // the clamps come into play; the rest is long rays, border cases and noise.
  function automatic ray_req_t random_item();
    int pick;
    int sub;
    pick = $urandom_range(0, 99);
    sub = $urandom_range(0, 9);
    if (pick < 8)
      return mk_req($urandom_range(0, 1), any16(), any16(), any16(), any16());
    if (pick < 30) begin
      if (sub < 7)
        return mk_req(REQ_READ, any16(), any16(),
                      win_r + $urandom_range(0, 7), win_c + $urandom_range(0, 7));
      if (sub < 9)
        return mk_req(REQ_READ, any16(), any16(),
                      $urandom_range(0, GRID_H - 1), $urandom_range(0, GRID_W - 1));
      return mk_req(REQ_READ, any16(), any16(), border_coord(), border_coord());
    end
    if (pick < 75)
      return mk_req(REQ_RAY, win_r + $urandom_range(0, 7), win_c + $urandom_range(0, 7),
                    win_r + $urandom_range(0, 7), win_c + $urandom_range(0, 7));
    if (pick < 92) begin
      if (sub < 5)
        return mk_req(REQ_RAY, win_r + $urandom_range(0, 7), win_c + $urandom_range(0, 7),
                      $urandom_range(0, GRID_H - 1), $urandom_range(0, GRID_W - 1));
      return mk_req(REQ_RAY, $urandom_range(0, GRID_H - 1), $urandom_range(0, GRID_W - 1),
                    $urandom_range(0, GRID_H - 1), $urandom_range(0, GRID_W - 1));
    end
    return mk_req(REQ_RAY, border_coord(), border_coord(), border_coord(), border_coord());
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Hang detector: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Response side: stall a random number of cycles, then take the next word
  // and compare it with the oldest owed response.
  initial begin
    int stall;
    ray_rsp_t want;
    wait (rst === 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      if (awaited_rsp.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected response, expected none, actual status %0d value %0d count %0d",
                 $time, rsp_ch.status, rsp_ch.cell_value, rsp_ch.cells_updated);
      end else begin
        want = awaited_rsp.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("cell_value", want.cell_value, rsp_ch.cell_value);
        check_field("cells_updated", want.cells_updated, rsp_ch.cells_updated);
      end
    end
  end

  initial begin
    ray_rsp_t none;
    none = '0;
    n_fail = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    rst = 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_FREE_INC;
    cfg_wr_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_RAY;
    req_ch.start_row <= '0;
    req_ch.start_col <= '0;
    req_ch.target_row <= '0;
    req_ch.target_col <= '0;
    rsp_ch.ready <= 1'b0;
    for (int i = 0; i < GRID_CELLS; i++) grid_lo[i] = '0;
    free_inc_m = int'(FREE_INC_RST);
    occ_inc_m = int'(OCC_INC_RST);
    lo_clamp_m = int'(LOWER_CLAMP_RST);
    hi_clamp_m = int'(UPPER_CLAMP_RST);

    // Directed rows, reset register values throughout.
    // Fresh grid reads zero; the start fields of a read are don't-care.
    add_row(mk_req(REQ_READ, 0, 0, 0, 0), 1, mk_rsp(ST_DONE, 0, 0));
    add_row(mk_req(REQ_READ, -32768, 32767, GRID_H - 1, GRID_W - 1), 1,
            mk_rsp(ST_DONE, 0, 0));
    // Reads off the map.
    add_row(mk_req(REQ_READ, 0, 0, -1, 0), 1, mk_rsp(ST_TARGET_OUT, 0, 0));
    add_row(mk_req(REQ_READ, 0, 0, 0, GRID_W), 1, mk_rsp(ST_TARGET_OUT, 0, 0));
    add_row(mk_req(REQ_READ, 32767, -32768, -32768, 32767), 1, mk_rsp(ST_TARGET_OUT, 0, 0));
    // Start off the map wins over target off the map.
    add_row(mk_req(REQ_RAY, -1, 5, 5, 5), 1, mk_rsp(ST_START_OUT, 0, 0));
    add_row(mk_req(REQ_RAY, 32767, -32768, -32768, 32767), 1, mk_rsp(ST_START_OUT, 0, 0));
    add_row(mk_req(REQ_RAY, 0, GRID_W, 3, 3), 1, mk_rsp(ST_START_OUT, 0, 0));
    add_row(mk_req(REQ_RAY, 0, 0, GRID_H, 0), 1, mk_rsp(ST_TARGET_OUT, 0, 0));
    add_row(mk_req(REQ_RAY, GRID_H - 1, GRID_W - 1, 0, -32768), 1,
            mk_rsp(ST_TARGET_OUT, 0, 0));
    // Zero-length ray: only the hit cell moves; repeat it up to the ceiling.
    add_row(mk_req(REQ_RAY, 10, 10, 10, 10), 1, mk_rsp(ST_DONE, 218, 1));
    add_row(mk_req(REQ_READ, 0, 0, 10, 10), 1, mk_rsp(ST_DONE, 218, 0));
    add_row(mk_req(REQ_RAY, 10, 10, 10, 10), 1, mk_rsp(ST_DONE, 436, 1));
    add_row(mk_req(REQ_RAY, 10, 10, 10, 10), 1, mk_rsp(ST_DONE, 654, 1));
    add_row(mk_req(REQ_RAY, 10, 10, 10, 10), 1, mk_rsp(ST_DONE, 872, 1));
    add_row(mk_req(REQ_RAY, 10, 10, 10, 10), 1, mk_rsp(ST_DONE, 1090, 1));
    add_row(mk_req(REQ_RAY, 10, 10, 10, 10), 1, mk_rsp(ST_DONE, 1280, 1));
    // Full-length rays: a row and the main diagonal.
    add_row(mk_req(REQ_RAY, 0, 0, 0, GRID_W - 1), 1, mk_rsp(ST_DONE, 218, GRID_W));
    add_row(mk_req(REQ_RAY, 0, 0, GRID_H - 1, GRID_W - 1), 1, mk_rsp(ST_DONE, 218, GRID_W));
    // Rays in four directions, then two reads, left to the shadow grid.
    add_row(mk_req(REQ_RAY, GRID_H - 1, 0, 0, 0), 0, none);
    add_row(mk_req(REQ_RAY, 0, GRID_W - 1, GRID_H - 1, 0), 0, none);
    add_row(mk_req(REQ_RAY, 5, 5, 100, 37), 0, none);
    add_row(mk_req(REQ_RAY, 200, 40, 12, 180), 0, none);
    add_row(mk_req(REQ_READ, 0, 0, 0, 0), 0, none);
    add_row(mk_req(REQ_READ, 0, 0, 128, 128), 0, none);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].known, dir_rows[i].rs);

    for (int ph = 0; ph < PHASES; ph++) begin
      // Registers change only with the block idle.
      if (ph > 0) begin
        drain_results(4);
        case (ph)
          1: write_cfg(-32768, 32767, -32768, 32767);
          2: write_cfg(32767, -32768, 32767, -32768);
          3: write_cfg(FREE_INC_RST, OCC_INC_RST, LOWER_CLAMP_RST, UPPER_CLAMP_RST);
          4: write_cfg(32767, 32767, -32768, 32767);
          5: write_cfg(-32768, -32768, -32768, 32767);
          default: begin
            if ($urandom_range(0, 1) == 1)
              write_cfg(any16(), any16(), any16(), any16());
            else
              write_cfg(-$urandom_range(0, 3000), $urandom_range(0, 3000),
                        -$urandom_range(0, 8000), $urandom_range(0, 8000));
          end
        endcase
      end
      no_idle = ($urandom_range(0, 3) == 0);
      win_r = $urandom_range(0, GRID_H - 8);
      win_c = $urandom_range(0, GRID_W - 8);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Now and then hold the sender until the block runs dry.
        if ($urandom_range(0, 39) == 0) drain_results(1);
        send_req(random_item(), 0, none);
      end
    end

    drain_results(TAIL_CYCLES);
    if (n_fail == 0 && awaited_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/ogru_pkg.sv
design/ogru_if.sv
design/ogru_ram.sv
design/ogru_queue.sv
design/ogru_front.sv
design/ogru_back.sv
design/occupancy_grid_ray_update_unit.sv
sim/tb_occupancy_grid_ray_update_unit.sv
